// ----- src/ps2mt_pkg.sv -----
`timescale 1ns / 1ps

package ps2mt_pkg;

    // cursor coordinate width used unless the top level is told otherwise
    localparam int COORD_BITS_DEF = 12;

    localparam int IN_W  = 8;
    localparam int CFG_W = 13;
    localparam int IDX_W = 1;

    localparam logic [IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd1024;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd768;

    // header bit positions
    localparam int HDR_LEFT     = 0;
    localparam int HDR_RIGHT    = 1;
    localparam int HDR_MIDDLE   = 2;
    localparam int HDR_ONE      = 3;
    localparam int HDR_X_SIGN   = 4;
    localparam int HDR_Y_SIGN   = 5;
    localparam int HDR_X_OVF    = 6;
    localparam int HDR_Y_OVF    = 7;

    // movement is {sign, byte} as a 9-bit value, widened to hold the overflow step
    localparam int MOVE_W = 10;
    localparam logic signed [MOVE_W-1:0] OVF_EXTRA = 10'sd255;

    // byte phase codes
    localparam logic [1:0] PH_HDR = 2'd0;
    localparam logic [1:0] PH_X   = 2'd1;
    localparam logic [1:0] PH_Y   = 2'd2;

endpackage

// ----- src/ps2mt_axis.sv -----
`timescale 1ns / 1ps

module ps2mt_axis #(
    parameter int COORD_BITS = ps2mt_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0]       i_pos,
    input  logic [ps2mt_pkg::IN_W-1:0]  i_move,
    input  logic                        i_sign,
    input  logic                        i_ovf,
    input  logic                        i_invert,
    input  logic [ps2mt_pkg::CFG_W-1:0] i_size,
    output logic [COORD_BITS-1:0]       o_pos
);
    import ps2mt_pkg::*;

    localparam int CMP_W = ((COORD_BITS > CFG_W) ? COORD_BITS : CFG_W) + 3;

    logic signed [MOVE_W-1:0] w_move;
    logic signed [CMP_W-1:0]  w_pos;
    logic signed [CMP_W-1:0]  w_step;
    logic signed [CMP_W-1:0]  w_sum;
    logic signed [CMP_W-1:0]  w_mask;
    logic signed [CMP_W-1:0]  w_top;
    logic signed [CMP_W-1:0]  w_lim;
    logic signed [CMP_W-1:0]  w_res;
    logic [CFG_W-1:0]         w_size_m1;

    always_comb begin
        // negative movement is byte minus 256, i.e. sign bit on top of the byte
        w_move = signed'({i_sign, i_sign, i_move});
        if (i_ovf) begin
            w_move = i_sign ? (w_move - OVF_EXTRA) : (w_move + OVF_EXTRA);
        end
        w_pos  = signed'({{(CMP_W-COORD_BITS){1'b0}}, i_pos});
        w_step = signed'({{(CMP_W-MOVE_W){w_move[MOVE_W-1]}}, w_move});
        w_sum  = i_invert ? (w_pos - w_step) : (w_pos + w_step);

        // a zero size acts as one
        w_size_m1 = (i_size == '0) ? '0 : (i_size - CFG_W'(1));
        w_top     = signed'({{(CMP_W-CFG_W){1'b0}}, w_size_m1});
        w_mask    = signed'({{(CMP_W-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}});
        w_lim     = (w_top > w_mask) ? w_mask : w_top;

        if (w_sum < 0) begin
            w_res = '0;
        end else if (w_sum > w_lim) begin
            w_res = w_lim;
        end else begin
            w_res = w_sum;
        end
        o_pos = w_res[COORD_BITS-1:0];
    end

endmodule

// ----- src/ps2_mouse_packet_tracker.sv -----
`timescale 1ns / 1ps
// a byte is registered on acceptance and decoded from that register; the result of
// a third packet byte is then registered in the output register
// throughput: one byte per cycle unless a third packet byte waits for the output
// register; header and X bytes are still decoded while a result waits to be taken
// reset (synchronous, active low) clears the byte phase and cursor, screen size to default

module ps2_mouse_packet_tracker #(
    parameter int COORD_BITS = ps2mt_pkg::COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // rx_byte[7:0]
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [ps2mt_pkg::IN_W-1:0]  i_s_axis_tdata,
    // cursor_x, cursor_y, left_button, right_button, middle_button, zero fill
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [((2*COORD_BITS+10)/8)*8-1:0] o_m_axis_tdata,
    input  logic                        i_cfg_we,
    input  logic [ps2mt_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [ps2mt_pkg::CFG_W-1:0] i_cfg_data
);
    import ps2mt_pkg::*;

    localparam int RES_W = 2*COORD_BITS + 3;
    localparam int OUT_W = ((2*COORD_BITS+10)/8)*8;

    logic                  r_in_valid;
    logic [IN_W-1:0]       r_in_byte;
    logic [1:0]            r_phase;
    logic [IN_W-1:0]       r_header;
    logic [IN_W-1:0]       r_x_move;
    logic [COORD_BITS-1:0] r_pos_x;
    logic [COORD_BITS-1:0] r_pos_y;
    logic [CFG_W-1:0]      r_width;
    logic [CFG_W-1:0]      r_height;
    logic                  r_out_valid;
    logic [RES_W-1:0]      r_out_data;

    logic                  w_is_result;
    logic                  w_out_free;
    logic                  w_go;
    logic                  w_take;
    logic [COORD_BITS-1:0] n_pos_x;
    logic [COORD_BITS-1:0] n_pos_y;

    ps2mt_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
        .i_pos    (r_pos_x),
        .i_move   (r_x_move),
        .i_sign   (r_header[HDR_X_SIGN]),
        .i_ovf    (r_header[HDR_X_OVF]),
        .i_invert (1'b0),
        .i_size   (r_width),
        .o_pos    (n_pos_x)
    );

    // rows grow downward, so Y movement is subtracted
    ps2mt_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
        .i_pos    (r_pos_y),
        .i_move   (r_in_byte),
        .i_sign   (r_header[HDR_Y_SIGN]),
        .i_ovf    (r_header[HDR_Y_OVF]),
        .i_invert (1'b1),
        .i_size   (r_height),
        .o_pos    (n_pos_y)
    );

    assign w_is_result     = (r_phase == PH_Y);
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_go            = r_in_valid && (!w_is_result || w_out_free);
    assign o_s_axis_tready = i_rst_n && (!r_in_valid || w_go);
    assign w_take          = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_W-RES_W){1'b0}}, r_out_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDX_WIDTH:  r_width  <= i_cfg_data;
                CFG_IDX_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR;
            r_header <= '0;
            r_x_move <= '0;
            r_pos_x  <= '0;
            r_pos_y  <= '0;
        end else if (w_go) begin
            case (r_phase)
                PH_X: begin
                    r_x_move <= r_in_byte;
                    r_phase  <= PH_Y;
                end
                PH_Y: begin
                    r_pos_x <= n_pos_x;
                    r_pos_y <= n_pos_y;
                    r_phase <= PH_HDR;
                end
                default: begin
                    // a header without its always-one bit is dropped
                    if (r_in_byte[HDR_ONE]) begin
                        r_header <= r_in_byte;
                        r_phase  <= PH_X;
                    end else begin
                        r_phase  <= PH_HDR;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && w_is_result) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_is_result) begin
            r_out_data <= {r_header[HDR_MIDDLE], r_header[HDR_RIGHT], r_header[HDR_LEFT],
                           n_pos_y, n_pos_x};
        end
    end

endmodule

// ----- src/ps2mt_checker.sv -----
`timescale 1ns / 1ps

module ps2mt_checker #(
    parameter int COORD_BITS = ps2mt_pkg::COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    input  logic                        o_s_axis_tready,
    input  logic [ps2mt_pkg::IN_W-1:0]  i_s_axis_tdata,
    input  logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    input  logic [((2*COORD_BITS+10)/8)*8-1:0] o_m_axis_tdata,
    input  logic                        i_cfg_we,
    input  logic [ps2mt_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [ps2mt_pkg::CFG_W-1:0] i_cfg_data
);
    import ps2mt_pkg::*;

    logic w_unused;
    assign w_unused = ^{i_s_axis_tdata, i_cfg_we, i_cfg_index, i_cfg_data};

    // a stalled result keeps its request and data
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // a fresh result is always caused by a byte taken at the input and held in the input register
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(i_s_axis_tvalid && o_s_axis_tready && i_rst_n, 2))
        else $error("result without a byte taken");

    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_m_axis_tvalid) |-> $past(i_m_axis_tready))
        else $error("result lost before being taken");

endmodule

bind ps2_mouse_packet_tracker ps2mt_checker #(.COORD_BITS(COORD_BITS)) u_ps2mt_checker (.*);

// ----- dv/ps2_mouse_packet_tracker_test.sv -----
`timescale 1ns / 1ps

module ps2_mouse_packet_tracker_test;

    import ps2mt_pkg::*;

    localparam int COORD_BITS = COORD_BITS_DEF;
    localparam int OUT_W      = ((2*COORD_BITS+10)/8)*8;
    localparam int COORD_TOP  = (1 << COORD_BITS) - 1;
    localparam int SIGN_SPAN  = 256;
    localparam int OVF_STEP   = 255;
    localparam int LONG_HOLD  = 300;
    localparam int SETTLE     = 4;
    localparam int WATCHDOG   = 3000;
    localparam int PLAN_LEN   = 26;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  left;
        logic                  right;
        logic                  middle;
    } cursor_t;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        cursor_t    want;
    } plan_row_t;

    localparam cursor_t NO_CURSOR = '0;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [IN_W-1:0]      s_tdata = '0;
    logic                 m_tready = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [IDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [OUT_W-1:0]     o_m_axis_tdata;

    // tracker state kept alongside the block
    logic [1:0]            pkt_phase = PH_HDR;
    logic [7:0]            hdr_held = '0;
    logic [7:0]            x_move = '0;
    logic [COORD_BITS-1:0] cur_x = '0;
    logic [COORD_BITS-1:0] cur_y = '0;
    logic [CFG_W-1:0]      screen_w = WIDTH_RST;
    logic [CFG_W-1:0]      screen_h = HEIGHT_RST;

    cursor_t cursor_q[$];
    int      mismatches = 0;
    int      sender_idle = 0;
    int      receiver_idle = 0;
    int      hold_orders = 0;
    int      holds_served = 0;
    int      hold_left = 0;
    int      quiet_cycles = 0;

    // headers without bit 3 first, then sign, overflow and clamp corners
    plan_row_t stim_plan [PLAN_LEN] = '{
        '{8'h00, 1'b0, NO_CURSOR},
        '{8'h37, 1'b0, NO_CURSOR},
        '{8'h08, 1'b0, NO_CURSOR},
        '{8'h00, 1'b0, NO_CURSOR},
        '{8'h00, 1'b1, '{12'd0, 12'd0, 1'b0, 1'b0, 1'b0}},
        '{8'h0F, 1'b0, NO_CURSOR},
        '{8'hFF, 1'b0, NO_CURSOR},
        '{8'h00, 1'b1, '{12'd255, 12'd0, 1'b1, 1'b1, 1'b1}},
        '{8'h48, 1'b0, NO_CURSOR},
        '{8'hFF, 1'b0, NO_CURSOR},
        '{8'h00, 1'b1, '{12'd765, 12'd0, 1'b0, 1'b0, 1'b0}},
        '{8'h48, 1'b0, NO_CURSOR},
        '{8'hFF, 1'b0, NO_CURSOR},
        '{8'h00, 1'b1, '{12'd1023, 12'd0, 1'b0, 1'b0, 1'b0}},
        '{8'hA8, 1'b0, NO_CURSOR},
        '{8'h01, 1'b0, NO_CURSOR},
        '{8'h01, 1'b0, NO_CURSOR},
        '{8'hF8, 1'b0, NO_CURSOR},
        '{8'h00, 1'b0, NO_CURSOR},
        '{8'h00, 1'b0, NO_CURSOR},
        '{8'hD8, 1'b0, NO_CURSOR},
        '{8'h01, 1'b0, NO_CURSOR},
        '{8'hFF, 1'b0, NO_CURSOR},
        '{8'h5F, 1'b0, NO_CURSOR},
        '{8'h80, 1'b0, NO_CURSOR},
        '{8'h7F, 1'b0, NO_CURSOR}
    };

    ps2_mouse_packet_tracker #(
        .COORD_BITS(COORD_BITS)
    ) DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int move_amount(input logic [7:0] mag, input logic neg,
                                       input logic ovf);
        int m;
        m = neg ? SIGN_SPAN - int'(mag) : int'(mag);
        if (ovf) m += OVF_STEP;
        return neg ? -m : m;
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_to(input int v, input int size);
        int top;
        top = (size == 0) ? 0 : size - 1;
        if (top > COORD_TOP) top = COORD_TOP;
        if (v < 0) return '0;
        if (v > top) return top[COORD_BITS-1:0];
        return v[COORD_BITS-1:0];
    endfunction

    // returns 1 when the byte closes a packet and a cursor update is due
    function automatic bit advance_tracker(input logic [7:0] b, output cursor_t res);
        int dx;
        int dy;
        res = '0;
        if (pkt_phase == PH_X) begin
            x_move = b;
            pkt_phase = PH_Y;
            return 1'b0;
        end
        if (pkt_phase != PH_Y) begin
            pkt_phase = PH_HDR;
            if (b[HDR_ONE]) begin
                hdr_held = b;
                pkt_phase = PH_X;
            end
            return 1'b0;
        end
        pkt_phase = PH_HDR;
        dx = move_amount(x_move, hdr_held[HDR_X_SIGN], hdr_held[HDR_X_OVF]);
        dy = move_amount(b, hdr_held[HDR_Y_SIGN], hdr_held[HDR_Y_OVF]);
        cur_x = clamp_to(int'(cur_x) + dx, int'(screen_w));
        cur_y = clamp_to(int'(cur_y) - dy, int'(screen_h));
        res.x = cur_x;
        res.y = cur_y;
        res.left = hdr_held[HDR_LEFT];
        res.right = hdr_held[HDR_RIGHT];
        res.middle = hdr_held[HDR_MIDDLE];
        return 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic typed, input cursor_t want);
        cursor_t res;
        @(negedge clk);
        while ($urandom_range(99) < sender_idle) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge clk); while (!o_s_axis_tready);
        if (advance_tracker(b, res)) cursor_q.push_back(typed ? want : res);
    endtask

    // lower the request and let any header or x byte in flight settle
    task automatic wait_drained;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (cursor_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_screen(input int w, input int h);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_IDX_WIDTH;
        cfg_data <= w[CFG_W-1:0];
        @(negedge clk);
        cfg_index <= CFG_IDX_HEIGHT;
        cfg_data <= h[CFG_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        screen_w = w[CFG_W-1:0];
        screen_h = h[CFG_W-1:0];
    endtask

    // mostly framed packets with random content, some stray bytes that break framing
    task automatic random_traffic(input int n);
        int sent;
        logic [7:0] hdr;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(99) < 85) begin
                hdr = 8'($urandom_range(255));
                hdr[HDR_ONE] = 1'b1;
                if ($urandom_range(3) != 0) begin
                    hdr[HDR_X_OVF] = 1'b0;
                    hdr[HDR_Y_OVF] = 1'b0;
                end
                send_byte(hdr, 1'b0, NO_CURSOR);
                send_byte(8'($urandom_range(255)), 1'b0, NO_CURSOR);
                send_byte(8'($urandom_range(255)), 1'b0, NO_CURSOR);
                sent += 3;
            end else begin
                send_byte(8'($urandom_range(255)), 1'b0, NO_CURSOR);
            end
        end
    endtask

    task automatic run_phase(input int w, input int h, input int s_idle, input int r_idle,
                             input int n);
        wait_drained();
        set_screen(w, h);
        sender_idle = s_idle;
        receiver_idle = r_idle;
        random_traffic(n);
    endtask

    task automatic report(input string field, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    endtask

    // receiver side, with a long hold-off whenever one is ordered
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (holds_served != hold_orders) begin
            holds_served = holds_served + 1;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_idle);
        end
    end

    always @(posedge clk) begin : check_results
        cursor_t got;
        cursor_t want;
        if (rst_n && o_m_axis_tvalid && m_tready) begin
            got.x = o_m_axis_tdata[COORD_BITS-1:0];
            got.y = o_m_axis_tdata[2*COORD_BITS-1:COORD_BITS];
            got.left = o_m_axis_tdata[2*COORD_BITS];
            got.right = o_m_axis_tdata[2*COORD_BITS+1];
            got.middle = o_m_axis_tdata[2*COORD_BITS+2];
            if (cursor_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected cursor update x=%0d y=%0d", got.x, got.y);
            end else begin
                want = cursor_q.pop_front();
                if (got.x !== want.x) report("cursor_x", want.x, got.x);
                if (got.y !== want.y) report("cursor_y", want.y, got.y);
                if (got.left !== want.left) report("left_button", want.left, got.left);
                if (got.right !== want.right) report("right_button", want.right, got.right);
                if (got.middle !== want.middle)
                    report("middle_button", want.middle, got.middle);
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("ps2_mouse_packet_tracker regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int i;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // default screen straight after reset
        for (i = 0; i < PLAN_LEN; i++)
            send_byte(stim_plan[i].rx, stim_plan[i].typed, stim_plan[i].want);

        run_phase(4096, 4096, 0, 0, 160);
        run_phase(1, 1, 57, 0, 160);
        run_phase(0, 8191, 0, 57, 160);
        run_phase(640, 480, 22, 22, 160);

        // receiver holds off while bytes keep coming, so the input backs up
        wait_drained();
        set_screen($urandom_range(4096, 1), $urandom_range(4096, 1));
        sender_idle = 0;
        receiver_idle = 0;
        hold_orders++;
        random_traffic(160);

        // sender pauses mid-phase until every cursor update is out
        run_phase($urandom_range(8191), $urandom_range(8191), 57, 57, 80);
        wait_drained();
        random_traffic(80);

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("ps2_mouse_packet_tracker regression: pass");
        else
            $display("ps2_mouse_packet_tracker regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
src/ps2mt_pkg.sv
src/ps2mt_axis.sv
src/ps2_mouse_packet_tracker.sv
src/ps2mt_checker.sv
dv/ps2_mouse_packet_tracker_test.sv
